>>> hw/rtl/gcuwc_pkg.sv
// ----------------------------------------------------------------------------
// gcuwc_pkg
// Shared types and constants of the grid cell union wall carver.
// ----------------------------------------------------------------------------
package gcuwc_pkg;

  localparam int MAX_SIDE_DEF  = 32;
  localparam int MAX_CELLS_DEF = 1024;

  localparam int GRID_SIDE_W = 6;   // grid_side register
  localparam int SIDE_W      = 7;   // effective side, at most 63
  localparam int COORD_W     = 5;
  localparam int DIR_W       = 2;
  localparam int WALL_W      = 7;
  localparam int COUNT_W     = 11;
  localparam int AREA_W      = 14;  // side*side and cell positions
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [GRID_SIDE_W-1:0] GRID_SIDE_RST = GRID_SIDE_W'(32);

  // word index of a register within the config space (paddr[2])
  localparam logic REG_GRID_SIDE = 1'b0;

  typedef enum logic [DIR_W-1:0] {
    DIR_LEFT  = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_UP    = 2'd2,
    DIR_DOWN  = 2'd3
  } dir_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_LOOKUP,
    ST_MERGE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic init;      // load identity labels
    logic relabel;   // replace la with lb while shifting
  } ring_ctl_t;

  typedef struct packed {
    dir_t               direction;
    logic [COORD_W-1:0] cell_col;
    logic [COORD_W-1:0] cell_row;
  } in_item_t;

  typedef struct packed {
    logic               done_res;
    logic [COUNT_W-1:0] sets_left;
    logic [WALL_W-1:0]  wall_col;
    logic [WALL_W-1:0]  wall_row;
    logic               ignored;
    logic               carved;
  } out_item_t;

endpackage

>>> hw/rtl/gcuwc_cell.sv
// ----------------------------------------------------------------------------
// gcuwc_cell
// One label cell of the rotating label ring.
// ----------------------------------------------------------------------------
module gcuwc_cell #(
  parameter int          IW   = 10,
  parameter int unsigned INIT = 0
) (
  input  logic                 clk,
  input  gcuwc_pkg::ring_ctl_t ring_ctl,
  input  logic [IW-1:0]        la,
  input  logic [IW-1:0]        lb,
  input  logic [IW-1:0]        label_in,
  output logic [IW-1:0]        label_r
);

  logic [IW-1:0] label_nxt;

  always_comb begin
    if (ring_ctl.init) begin
      label_nxt = IW'(INIT);
    end else if (ring_ctl.relabel && (label_in == la)) begin
      label_nxt = lb;
    end else begin
      label_nxt = label_in;
    end
  end

  always_ff @(posedge clk) begin
    label_r <= label_nxt;
  end

endmodule

>>> hw/rtl/gcuwc_ctrl.sv
// ----------------------------------------------------------------------------
// gcuwc_ctrl
// Config register, item sequencer, ring position tracking and result register.
// ----------------------------------------------------------------------------
module gcuwc_ctrl #(
  parameter int MAX_SIDE  = gcuwc_pkg::MAX_SIDE_DEF,
  parameter int MAX_CELLS = gcuwc_pkg::MAX_CELLS_DEF,
  parameter int IW        = $clog2(MAX_CELLS)
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [gcuwc_pkg::GRID_SIDE_W-1:0]    cfg_wdata,
  output logic [gcuwc_pkg::GRID_SIDE_W-1:0]    grid_side,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  gcuwc_pkg::in_item_t                  in_item,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output gcuwc_pkg::out_item_t                 out_item,
  input  logic [IW-1:0]                        head_label,
  output gcuwc_pkg::ring_ctl_t                 ring_ctl,
  output logic [IW-1:0]                        la,
  output logic [IW-1:0]                        lb
);

  localparam int SW = gcuwc_pkg::SIDE_W;
  localparam int AW = gcuwc_pkg::AREA_W;
  localparam int CW = gcuwc_pkg::COUNT_W;
  localparam int WW = gcuwc_pkg::WALL_W;
  localparam logic [SW-1:0] MAX_SIDE_C  = SW'(MAX_SIDE);
  localparam logic [AW-1:0] MAX_CELLS_C = AW'(MAX_CELLS);
  localparam logic [IW-1:0] LAST_POS    = IW'(MAX_CELLS - 1);

  gcuwc_pkg::state_t    state_r, state_nxt;
  logic [gcuwc_pkg::GRID_SIDE_W-1:0] grid_side_r;
  logic                 restart_r;
  logic [IW-1:0]        rot_r, rot_nxt;
  gcuwc_pkg::in_item_t  item_r;
  logic [IW-1:0]        a_r, b_r;
  logic                 ign_r, carved_r;
  logic [WW-1:0]        wr_r, wc_r;
  logic                 got_a_r, got_b_r;
  logic [IW-1:0]        la_r, lb_r;
  logic [CW-1:0]        count_r;
  logic                 out_valid_r;
  gcuwc_pkg::out_item_t out_item_r;

  // effective side and starting set count
  logic [SW-1:0] side;
  logic [AW-1:0] area, area_cap;
  always_comb begin
    if (grid_side_r == '0) begin
      side = SW'(1);
    end else if ({1'b0, grid_side_r} > MAX_SIDE_C) begin
      side = MAX_SIDE_C;
    end else begin
      side = {1'b0, grid_side_r};
    end
    area     = AW'(side) * AW'(side);
    area_cap = (area > MAX_CELLS_C) ? MAX_CELLS_C : area;
  end

  // neighbor and position calculation
  logic [SW-1:0] rs, cs, nr, nc;
  logic          off;
  logic [AW-1:0] pos_a, pos_b;
  logic          in_range;
  always_comb begin
    rs  = SW'(item_r.cell_row);
    cs  = SW'(item_r.cell_col);
    nr  = rs;
    nc  = cs;
    off = (rs >= side) || (cs >= side);
    unique case (item_r.direction)
      gcuwc_pkg::DIR_LEFT: begin
        if (cs == '0) off = 1'b1;
        else nc = cs - SW'(1);
      end
      gcuwc_pkg::DIR_RIGHT: nc = cs + SW'(1);
      gcuwc_pkg::DIR_UP: begin
        if (rs == '0) off = 1'b1;
        else nr = rs - SW'(1);
      end
      gcuwc_pkg::DIR_DOWN: nr = rs + SW'(1);
      default: off = 1'b1;
    endcase
    if ((nr >= side) || (nc >= side)) off = 1'b1;
    pos_a    = AW'(rs) * AW'(side) + AW'(cs);
    pos_b    = AW'(nr) * AW'(side) + AW'(nc);
    in_range = (pos_a < MAX_CELLS_C) && (pos_b < MAX_CELLS_C);
  end

  // ring head lookups
  logic hit_a, hit_b, both_found, diff;
  assign hit_a      = (rot_r == a_r);
  assign hit_b      = (rot_r == b_r);
  assign both_found = (got_a_r || hit_a) && (got_b_r || hit_b);
  assign diff       = (la_r != lb_r);
  assign rot_nxt    = restart_r ? '0 : ((rot_r == LAST_POS) ? '0 : rot_r + IW'(1));

  logic out_free;
  assign out_free = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gcuwc_pkg::ST_IDLE:   if (in_valid && in_ready) state_nxt = gcuwc_pkg::ST_CALC;
      gcuwc_pkg::ST_CALC:   state_nxt = (off || !in_range) ? gcuwc_pkg::ST_OUT
                                                           : gcuwc_pkg::ST_LOOKUP;
      gcuwc_pkg::ST_LOOKUP: if (both_found) state_nxt = gcuwc_pkg::ST_MERGE;
      gcuwc_pkg::ST_MERGE:  state_nxt = gcuwc_pkg::ST_OUT;
      gcuwc_pkg::ST_OUT:    if (out_free) state_nxt = gcuwc_pkg::ST_IDLE;
      default:              state_nxt = gcuwc_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready         = (state_r == gcuwc_pkg::ST_IDLE) && !restart_r;
    ring_ctl.init    = restart_r;
    ring_ctl.relabel = (state_r == gcuwc_pkg::ST_MERGE) && diff;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gcuwc_pkg::ST_IDLE;
      grid_side_r <= gcuwc_pkg::GRID_SIDE_RST;
      restart_r   <= 1'b1;
      rot_r       <= '0;
      out_valid_r <= 1'b0;
      got_a_r     <= 1'b0;
      got_b_r     <= 1'b0;
      count_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      restart_r <= cfg_wr_en;
      rot_r     <= rot_nxt;
      if (cfg_wr_en) grid_side_r <= cfg_wdata;
      if (restart_r) count_r <= CW'(area_cap);
      else if ((state_r == gcuwc_pkg::ST_MERGE) && diff && (count_r > CW'(1)))
        count_r <= count_r - CW'(1);
      if (state_r == gcuwc_pkg::ST_CALC) begin
        got_a_r <= 1'b0;
        got_b_r <= 1'b0;
      end else if (state_r == gcuwc_pkg::ST_LOOKUP) begin
        if (hit_a) got_a_r <= 1'b1;
        if (hit_b) got_b_r <= 1'b1;
      end
      if ((state_r == gcuwc_pkg::ST_OUT) && out_free) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) item_r <= in_item;
    if (state_r == gcuwc_pkg::ST_CALC) begin
      a_r      <= IW'(pos_a);
      b_r      <= IW'(pos_b);
      ign_r    <= off || !in_range;
      carved_r <= 1'b0;
      wr_r     <= WW'(rs) + WW'(nr) + WW'(1);
      wc_r     <= WW'(cs) + WW'(nc) + WW'(1);
    end
    if (state_r == gcuwc_pkg::ST_LOOKUP) begin
      if (hit_a) la_r <= head_label;
      if (hit_b) lb_r <= head_label;
    end
    if (state_r == gcuwc_pkg::ST_MERGE) carved_r <= diff;
    if ((state_r == gcuwc_pkg::ST_OUT) && out_free) begin
      out_item_r.carved    <= carved_r;
      out_item_r.ignored   <= ign_r;
      out_item_r.wall_row  <= carved_r ? wr_r : '0;
      out_item_r.wall_col  <= carved_r ? wc_r : '0;
      out_item_r.sets_left <= count_r;
      out_item_r.done_res  <= (count_r == CW'(1));
    end
  end

  assign grid_side = grid_side_r;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign la        = la_r;
  assign lb        = lb_r;

  a_merge_found: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gcuwc_pkg::ST_MERGE) |-> (got_a_r && got_b_r))
    else $error("merge entered before both labels were captured");

  a_count_dec: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == gcuwc_pkg::ST_MERGE) && diff && (count_r > CW'(1)) && !restart_r)
      |=> (count_r == CW'($past(count_r) - CW'(1))))
    else $error("set count did not drop after a merge");

  a_carve_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_item_r.carved && out_item_r.ignored))
    else $error("result both carved and ignored");

  a_restart_idle: assert property (@(posedge clk) disable iff (!rst_n)
    restart_r |-> (state_r == gcuwc_pkg::ST_IDLE))
    else $error("grid restart while an item is in flight");

endmodule

>>> hw/rtl/grid_cell_union_wall_carver_unit.sv
// ----------------------------------------------------------------------------
// grid_cell_union_wall_carver_unit
// Maze carver with a rotating ring of per-cell set labels.
// ----------------------------------------------------------------------------
// Input items (in_*) name a cell and a direction; every item yields exactly
// one result item (out_*) with carved/ignored flags, the wall pixel, the
// number of sets left and a done flag. grid_side is written over the APB
// port at address 0; a write restarts the grid (identity labels, set count
// of side squared, capped at MAX_CELLS).
// The labels sit in a ring of MAX_CELLS cells that shifts by one every
// cycle; the cell at the head is the only place labels are read. A lookup
// waits until both cells of the pair have passed the head; an ignored item
// goes from the position step straight to the output step, and any other
// item goes through lookup and merge first. The merge relabels all cells
// while the ring shifts. One item is in work at a time; a new item is
// accepted as soon as the previous result sits in the output register.
// After reset, in_tready rises once the grid restart is done.
// If the receiver stalls, the result is held and the next item runs up to
// its output step, then waits.
// ----------------------------------------------------------------------------
module grid_cell_union_wall_carver_unit #(
  parameter int MAX_SIDE  = gcuwc_pkg::MAX_SIDE_DEF,
  parameter int MAX_CELLS = gcuwc_pkg::MAX_CELLS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [gcuwc_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [gcuwc_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [gcuwc_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                                cfg_pready,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // cell_row[4:0], cell_col[9:5], direction[11:10], zero[15:12]
  input  logic [15:0]                         in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // carved[0], ignored[1], wall_row[8:2], wall_col[15:9], sets_left[26:16],
  // done_res[27], zero[31:28]
  output logic [31:0]                         out_tdata
);

  localparam int IW = $clog2(MAX_CELLS);
  localparam int IN_W  = $bits(gcuwc_pkg::in_item_t);
  localparam int OUT_W = $bits(gcuwc_pkg::out_item_t);

  logic                               cfg_wr_en;
  logic [gcuwc_pkg::GRID_SIDE_W-1:0]  grid_side;
  gcuwc_pkg::in_item_t                in_item;
  gcuwc_pkg::out_item_t               out_item;
  gcuwc_pkg::ring_ctl_t               ring_ctl;
  logic [IW-1:0]                      la, lb;
  logic [IW-1:0]                      ring_q [MAX_CELLS];

  assign cfg_pready = 1'b1;
  assign cfg_wr_en  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[2] == gcuwc_pkg::REG_GRID_SIDE);
  assign cfg_prdata = (cfg_paddr[2] == gcuwc_pkg::REG_GRID_SIDE) ?
                      gcuwc_pkg::CFG_DATA_W'(grid_side) : '0;

  assign in_item   = gcuwc_pkg::in_item_t'(in_tdata[IN_W-1:0]);
  assign out_tdata = {{(32 - OUT_W){1'b0}}, out_item};

  gcuwc_ctrl #(
    .MAX_SIDE  (MAX_SIDE),
    .MAX_CELLS (MAX_CELLS),
    .IW        (IW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wdata  (cfg_pwdata[gcuwc_pkg::GRID_SIDE_W-1:0]),
    .grid_side  (grid_side),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_item   (out_item),
    .head_label (ring_q[0]),
    .ring_ctl   (ring_ctl),
    .la         (la),
    .lb         (lb)
  );

  // cell p holds the label of cell index (p + rotation) mod MAX_CELLS
  for (genvar p = 0; p < MAX_CELLS; p++) begin : g_ring
    localparam int NEXT = (p == MAX_CELLS - 1) ? 0 : p + 1;
    gcuwc_cell #(
      .IW   (IW),
      .INIT (p)
    ) u_cell (
      .clk      (clk),
      .ring_ctl (ring_ctl),
      .la       (la),
      .lb       (lb),
      .label_in (ring_q[NEXT]),
      .label_r  (ring_q[p])
    );
  end

endmodule

>>> bench/tb_grid_cell_union_wall_carver_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grid_cell_union_wall_carver_unit
// Self-checking bench for the maze wall carver. Each accepted cell/direction
// item is run through a set-label model of the grid, and every result item
// is compared field by field with the oldest prediction. Grid sizes change
// between phases, and most items pick on-grid cells so that small grids
// merge down to a single set.
// ----------------------------------------------------------------------------
module tb_grid_cell_union_wall_carver_unit;

  localparam int CELLS       = gcuwc_pkg::MAX_CELLS_DEF;
  localparam int SIDE_CAP    = gcuwc_pkg::MAX_SIDE_DEF;
  localparam int COORD_W     = gcuwc_pkg::COORD_W;
  localparam int WALL_W      = gcuwc_pkg::WALL_W;
  localparam int COUNT_W     = gcuwc_pkg::COUNT_W;
  localparam int GRID_SIDE_W = gcuwc_pkg::GRID_SIDE_W;
  localparam int CFG_ADDR_W  = gcuwc_pkg::CFG_ADDR_W;
  localparam int CFG_DATA_W  = gcuwc_pkg::CFG_DATA_W;
  localparam int LIMIT       = 4_000_000;
  localparam int PICK_GOAL   = 580;
  localparam int HOLD_LEN    = 4000;
  localparam int SETTLE      = 1100;
  localparam logic [CFG_ADDR_W-1:0] ADDR_GRID_SIDE = {gcuwc_pkg::REG_GRID_SIDE, 2'b00};

  class carve_board;
    logic [9:0]           label [CELLS];
    int unsigned          sets;
    int unsigned          side;
    gcuwc_pkg::out_item_t outcomes [$];
    int                   errors;

    function void restart(logic [GRID_SIDE_W-1:0] raw);
      int unsigned s;
      s    = 32'(raw);
      side = (s == 0) ? 1 : ((s > SIDE_CAP) ? SIDE_CAP : s);
      for (int i = 0; i < CELLS; i++) label[i] = 10'(i);
      sets = (side * side > CELLS) ? CELLS : side * side;
    endfunction

    function void note_pick(gcuwc_pkg::in_item_t pick);
      gcuwc_pkg::out_item_t res;
      int unsigned r, c, nr, nc;
      logic [9:0]  la, lb;
      bit          off;
      res = '0;
      r   = 32'(pick.cell_row);
      c   = 32'(pick.cell_col);
      nr  = r;
      nc  = c;
      off = (r >= side) || (c >= side);
      case (pick.direction)
        gcuwc_pkg::DIR_LEFT:  if (c == 0) off = 1'b1; else nc = c - 1;
        gcuwc_pkg::DIR_RIGHT: nc = c + 1;
        gcuwc_pkg::DIR_UP:    if (r == 0) off = 1'b1; else nr = r - 1;
        default:              nr = r + 1;
      endcase
      if (nr >= side || nc >= side) off = 1'b1;
      if (off) begin
        res.ignored = 1'b1;
      end else begin
        la = label[r * side + c];
        lb = label[nr * side + nc];
        if (la != lb) begin
          // chosen cell's set takes the neighbor's label
          for (int i = 0; i < side * side; i++)
            if (label[i] == la) label[i] = lb;
          if (sets > 1) sets--;
          res.carved   = 1'b1;
          res.wall_row = WALL_W'(r + nr + 1);
          res.wall_col = WALL_W'(c + nc + 1);
        end
      end
      res.sets_left = COUNT_W'(sets);
      res.done_res  = (sets == 1);
      outcomes.push_back(res);
    endfunction

    function void match_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_outcome(logic [31:0] word);
      gcuwc_pkg::out_item_t want, got;
      got = gcuwc_pkg::out_item_t'(word[27:0]);
      if (outcomes.size() == 0) begin
        errors++;
        $display("%0t: result 0x%h with nothing expected", $time, word);
        return;
      end
      want = outcomes.pop_front();
      match_field("carved", want.carved, got.carved);
      match_field("ignored", want.ignored, got.ignored);
      match_field("wall_row", want.wall_row, got.wall_row);
      match_field("wall_col", want.wall_col, got.wall_col);
      match_field("sets_left", want.sets_left, got.sets_left);
      match_field("done_res", want.done_res, got.done_res);
      match_field("pad", 0, 32'(word[31:28]));
    endfunction

    function int outstanding();
      return outcomes.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [15:0]           in_tdata;   // cell_row[4:0], cell_col[9:5], direction[11:10]
  logic                  out_tvalid;
  logic                  out_tready;
  logic [31:0]           out_tdata;  // carved, ignored, wall_row, wall_col, sets_left, done_res

  carve_board  board;
  bit          calm;
  int          stall_req;
  int          stall_ack;
  int          stall_left;
  int          sent;
  int unsigned cycles;

  grid_cell_union_wall_carver_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result side: check, then pick next ready (long hold when requested)
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_outcome(out_tdata);
    if (stall_req != stall_ack) begin
      stall_ack  = stall_req;
      stall_left = HOLD_LEN;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(99) >= 24);
    end
  end

  task automatic offer(input int row, input int col, input gcuwc_pkg::dir_t dir);
    gcuwc_pkg::in_item_t pick;
    pick.cell_row  = COORD_W'(row);
    pick.cell_col  = COORD_W'(col);
    pick.direction = dir;
    while (!calm && $urandom_range(99) < 24) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0000, pick};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_pick(pick);
    sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
  endtask

  task automatic write_side(input logic [GRID_SIDE_W-1:0] raw);
    logic [CFG_DATA_W-1:0] junk;
    junk = $urandom;
    drain();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_GRID_SIDE;
    cfg_pwdata  <= {junk[CFG_DATA_W-1:GRID_SIDE_W], raw};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    board.restart(raw);
  endtask

  initial begin
    int phase, roll, raw, side, quota;
    board = new();
    board.restart(gcuwc_pkg::GRID_SIDE_RST);
    rst_n       <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    out_tready  <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // full 32x32 grid from reset: edges, corners, merges and a same-set pair
    offer(0, 0, gcuwc_pkg::DIR_LEFT);
    offer(0, 0, gcuwc_pkg::DIR_UP);
    offer(31, 31, gcuwc_pkg::DIR_RIGHT);
    offer(31, 31, gcuwc_pkg::DIR_DOWN);
    offer(0, 0, gcuwc_pkg::DIR_RIGHT);
    offer(0, 1, gcuwc_pkg::DIR_LEFT);
    offer(0, 0, gcuwc_pkg::DIR_DOWN);
    offer(31, 31, gcuwc_pkg::DIR_LEFT);
    offer(31, 30, gcuwc_pkg::DIR_UP);
    offer(30, 30, gcuwc_pkg::DIR_DOWN);
    offer(31, 31, gcuwc_pkg::DIR_UP);

    // zero side acts as a single cell: all ignored, done throughout
    write_side(GRID_SIDE_W'(0));
    offer(0, 0, gcuwc_pkg::DIR_LEFT);
    offer(0, 0, gcuwc_pkg::DIR_RIGHT);
    offer(0, 0, gcuwc_pkg::DIR_UP);
    offer(0, 0, gcuwc_pkg::DIR_DOWN);
    offer(5, 9, gcuwc_pkg::DIR_RIGHT);

    // oversize side clamps to the full grid
    write_side(GRID_SIDE_W'(63));
    offer(31, 0, gcuwc_pkg::DIR_UP);
    offer(0, 31, gcuwc_pkg::DIR_LEFT);

    // 2x2 grid carved to completion, then a same-set item and an off-grid cell
    write_side(GRID_SIDE_W'(2));
    offer(0, 0, gcuwc_pkg::DIR_RIGHT);
    offer(0, 0, gcuwc_pkg::DIR_DOWN);
    offer(1, 1, gcuwc_pkg::DIR_UP);
    offer(1, 0, gcuwc_pkg::DIR_RIGHT);
    offer(3, 0, gcuwc_pkg::DIR_UP);

    phase = 0;
    while (sent < PICK_GOAL) begin
      roll = $urandom_range(99);
      if (roll < 75)      raw = $urandom_range(8, 2);
      else if (roll < 85) raw = $urandom_range(1, 0);
      else                raw = $urandom_range(63, 9);
      // no-idle stretch on a grid with plenty of merges
      if (phase == 2) raw = 8;
      side  = (raw == 0) ? 1 : ((raw > SIDE_CAP) ? SIDE_CAP : raw);
      quota = (side > 8) ? 12 : side * side * 3 + 4;
      if (quota > PICK_GOAL - sent) quota = PICK_GOAL - sent;
      write_side(GRID_SIDE_W'(raw));
      calm = (phase == 2);
      for (int k = 0; k < quota; k++) begin
        if (phase == 0 && k == 2) stall_req++;
        if (phase == 4 && k == quota / 2) drain();
        if ($urandom_range(99) < 85)
          offer($urandom_range(side - 1), $urandom_range(side - 1),
                gcuwc_pkg::dir_t'($urandom_range(3)));
        else
          offer($urandom_range(31), $urandom_range(31),
                gcuwc_pkg::dir_t'($urandom_range(3)));
      end
      calm = 1'b0;
      phase++;
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    if (board.errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/gcuwc_pkg.sv
hw/rtl/gcuwc_cell.sv
hw/rtl/gcuwc_ctrl.sv
hw/rtl/grid_cell_union_wall_carver_unit.sv
bench/tb_grid_cell_union_wall_carver_unit.sv
